@@ src/iisb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert sequence buffer package
// Shared widths, codes and the control word that steers the cell chain.
// ----------------------------------------------------------------------------
package iisb_pkg;

  localparam int DATA_W   = 32;
  localparam int CNT_W    = 7;
  localparam int STS_W    = 2;
  localparam int CAPACITY = 64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd2;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd3;

  typedef struct packed {
    logic             ins_en;
    logic [CNT_W-1:0] pos;
    logic             rot_en;
    logic [CNT_W-1:0] tail;
  } cell_ctl_t;

endpackage

@@ src/iisb_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence buffer cell
// Holds one stored word; shifts up on insert and rotates down on dump.
// ----------------------------------------------------------------------------
module iisb_cell
  import iisb_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] ins_d,
  input  logic signed [DATA_W-1:0] left_d,
  input  logic signed [DATA_W-1:0] right_d,
  input  logic signed [DATA_W-1:0] head_d,
  output logic signed [DATA_W-1:0] q
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic signed [DATA_W-1:0] q_r;
  logic signed [DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.ins_en) begin
      if (MY_IDX == ctl.pos) begin
        q_nxt = ins_d;
      end else if (MY_IDX > ctl.pos) begin
        q_nxt = left_d;
      end
    end else if (ctl.rot_en) begin
      if (MY_IDX == ctl.tail) begin
        q_nxt = head_d;
      end else if (MY_IDX < ctl.tail) begin
        q_nxt = right_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ src/indexed_insert_sequence_buffer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert sequence buffer
// Every accepted request returns a registered status word. A dump of N
// entries enters the dump state and then sends N words, one word per cycle
// while the output is not stalled, rotating the cell chain once around;
// input is stalled meanwhile. Reset empties the buffer and clears the output
// valid flag; output data and cell contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_insert_sequence_buffer_unit
  import iisb_pkg::*;
#(
  parameter int CAPACITY_P = CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_op,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_data,
  output logic [STS_W-1:0]         out_status,
  output logic [CNT_W-1:0]         out_count,
  output logic                     out_last
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY_P);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [CNT_W-1:0]         dcnt_r, dcnt_nxt;
  logic                     ovld_r, ovld_nxt;
  logic signed [DATA_W-1:0] odata_r, odata_nxt;
  logic [STS_W-1:0]         osts_r, osts_nxt;
  logic [CNT_W-1:0]         ocnt_r, ocnt_nxt;
  logic                     olast_r, olast_nxt;

  logic      out_free;
  logic      in_acc;
  logic      dump_step;
  cell_ctl_t ctl;

  logic signed [DATA_W-1:0] cell_q [CAPACITY_P];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY_P; gi++) begin : g_cell
      logic signed [DATA_W-1:0] left_d;
      logic signed [DATA_W-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = in_value;
      end else begin : g_mid_l
        assign left_d = cell_q[gi-1];
      end
      if (gi == CAPACITY_P - 1) begin : g_last
        assign right_d = cell_q[0];
      end else begin : g_mid_r
        assign right_d = cell_q[gi+1];
      end
      iisb_cell #(.IDX(gi)) u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .ins_d  (in_value),
        .left_d (left_d),
        .right_d(right_d),
        .head_d (cell_q[0]),
        .q      (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    out_free  = ~ovld_r | ~out_stall;
    in_stall  = (state_r != ST_IDLE) | ~out_free;
    in_acc    = in_valid & ~in_stall;
    dump_step = (state_r == ST_DUMP) & out_free;

    state_nxt = state_r;
    fill_nxt  = fill_r;
    dcnt_nxt  = dcnt_r;
    ovld_nxt  = ovld_r & out_stall;
    odata_nxt = odata_r;
    osts_nxt  = osts_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;

    ctl.ins_en = 1'b0;
    ctl.pos    = in_position;
    ctl.rot_en = dump_step;
    ctl.tail   = fill_r - CNT_W'(1);

    if (in_acc) begin
      ovld_nxt  = 1'b1;
      odata_nxt = '0;
      ocnt_nxt  = fill_r;
      olast_nxt = 1'b1;
      if (in_op == OP_INSERT) begin
        if (fill_r >= CAP_CNT) begin
          osts_nxt = STS_FULL;
        end else if (in_position > fill_r) begin
          osts_nxt = STS_RANGE;
        end else begin
          ctl.ins_en = 1'b1;
          fill_nxt   = fill_r + CNT_W'(1);
          ocnt_nxt   = fill_r + CNT_W'(1);
          osts_nxt   = STS_OK;
        end
      end else if (fill_r == '0) begin
        osts_nxt = STS_EMPTY;
      end else begin
        ovld_nxt  = 1'b0;
        dcnt_nxt  = '0;
        state_nxt = ST_DUMP;
      end
    end

    if (dump_step) begin
      ovld_nxt  = 1'b1;
      odata_nxt = cell_q[0];
      osts_nxt  = STS_OK;
      ocnt_nxt  = fill_r;
      olast_nxt = (dcnt_r == ctl.tail);
      dcnt_nxt  = dcnt_r + CNT_W'(1);
      if (dcnt_r == ctl.tail) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      dcnt_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      dcnt_r  <= dcnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    osts_r  <= osts_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid  = ovld_r;
  assign out_data   = odata_r;
  assign out_status = osts_r;
  assign out_count  = ocnt_r;
  assign out_last   = olast_r;

endmodule
